>>> hw/rtl/hpp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the HEADERS frame payload parser.
package hpp_pkg;

	localparam int unsigned LenW = 24;
	localparam int unsigned DepW = 31;

	localparam logic [2:0] KIND_PADLEN = 3'd0;
	localparam logic [2:0] KIND_PRIO   = 3'd1;
	localparam logic [2:0] KIND_FRAG   = 3'd2;
	localparam logic [2:0] KIND_PAD    = 3'd3;
	localparam logic [2:0] KIND_ERR    = 3'd4;

	// Header bytes ahead of the fragment.
	localparam logic [2:0] PADLEN_BYTES = 3'd1;
	localparam logic [2:0] PRIO_BYTES   = 3'd5;
	localparam logic [2:0] DEP_BYTES    = 3'd4;

	typedef struct packed {
		logic [7:0]      payload_byte;
		logic            frame_start;
		logic            padded_flag;
		logic            priority_flag;
		logic [LenW-1:0] payload_length;
	} in_t;

	typedef struct packed {
		logic [2:0]      byte_kind;
		logic [7:0]      data_byte;
		logic            exclusive_bit;
		logic [DepW-1:0] dependency_id;
		logic [7:0]      weight_value;
		logic [7:0]      pad_count;
		logic            frame_end;
	} out_t;

endpackage

>>> hw/rtl/hpp_front.sv
`timescale 1ns / 1ps
// Front end: frame state, byte classification and field capture.
module hpp_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  hpp_pkg::in_t in_data,
	output logic         push_valid,
	input  logic         push_ready,
	output hpp_pkg::out_t push_data
);
	import hpp_pkg::*;

	logic [LenW-1:0] pos_q, total_q;
	logic            padded_q, prio_q, excl_q, err_q;
	logic [7:0]      pad_q, weight_q;
	logic [DepW-1:0] dep_q;

	logic [LenW-1:0] pos_e, total_e, pos_n;
	logic            padded_e, prio_e, excl_e, err_e;
	logic [7:0]      pad_e, weight_e;
	logic [DepW-1:0] dep_e;
	logic [2:0]      hdr_e, s_e;
	logic [LenW-1:0] hdr_x, s_x, room, frag_end;
	logic [2:0]      kind;
	logic            last, in_frame, accept;
	logic [7:0]      b;

	assign b        = in_data.payload_byte;
	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;

	always_comb begin
		// A start replaces the open frame before the byte is classified.
		if (in_data.frame_start) begin
			padded_e = in_data.padded_flag;
			prio_e   = in_data.priority_flag;
			total_e  = in_data.payload_length;
			pos_e    = '0;
			pad_e    = '0;
			dep_e    = '0;
			excl_e   = 1'b0;
			weight_e = '0;
		end else begin
			padded_e = padded_q;
			prio_e   = prio_q;
			total_e  = total_q;
			pos_e    = pos_q;
			pad_e    = pad_q;
			dep_e    = dep_q;
			excl_e   = excl_q;
			weight_e = weight_q;
		end
		s_e   = padded_e ? PADLEN_BYTES : 3'd0;
		hdr_e = s_e + (prio_e ? PRIO_BYTES : 3'd0);
		hdr_x = {{(LenW-3){1'b0}}, hdr_e};
		s_x   = {{(LenW-3){1'b0}}, s_e};
		if (in_data.frame_start) begin
			err_e = total_e < hdr_x;
		end else begin
			err_e = err_q;
		end
		room     = total_e - hdr_x;
		in_frame = pos_e < total_e;
		last     = 1'b0;
		kind     = KIND_ERR;
		pos_n    = pos_e;
		if (in_frame) begin
			last  = pos_e == total_e - {{(LenW-1){1'b0}}, 1'b1};
			pos_n = pos_e + {{(LenW-1){1'b0}}, 1'b1};
			if (err_e) begin
				kind = KIND_ERR;
			end else if (padded_e && pos_e == '0) begin
				pad_e = b;
				kind  = KIND_PADLEN;
				if ({{(LenW-8){1'b0}}, b} > room) begin
					err_e = 1'b1;
					kind  = KIND_ERR;
				end
			end else if (prio_e && pos_e < s_x + {{(LenW-3){1'b0}}, DEP_BYTES}) begin
				if (pos_e == s_x) begin
					excl_e = b[7];
					dep_e  = {{(DepW-7){1'b0}}, b[6:0]};
				end else begin
					dep_e = {dep_e[DepW-9:0], b};
				end
				kind = KIND_PRIO;
			end else if (prio_e && pos_e == s_x + {{(LenW-3){1'b0}}, DEP_BYTES}) begin
				weight_e = b;
				kind     = KIND_PRIO;
			end else begin
				kind = KIND_PAD;
			end
		end
	end

	// Fragment bound uses the pad length as updated by this byte.
	assign frag_end = total_e - {{(LenW-8){1'b0}}, pad_e};

	always_comb begin
		push_valid              = in_valid;
		push_data.byte_kind     = kind;
		if (kind == KIND_PAD && pos_e < frag_end) begin
			push_data.byte_kind = KIND_FRAG;
		end
		push_data.data_byte     = b;
		push_data.exclusive_bit = excl_e;
		push_data.dependency_id = dep_e;
		push_data.weight_value  = weight_e;
		push_data.pad_count     = pad_e;
		push_data.frame_end     = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			total_q  <= '0;
			padded_q <= 1'b0;
			prio_q   <= 1'b0;
			pad_q    <= '0;
			dep_q    <= '0;
			excl_q   <= 1'b0;
			weight_q <= '0;
			err_q    <= 1'b0;
		end else if (accept) begin
			pos_q    <= pos_n;
			total_q  <= total_e;
			padded_q <= padded_e;
			prio_q   <= prio_e;
			pad_q    <= pad_e;
			dep_q    <= dep_e;
			excl_q   <= excl_e;
			weight_q <= weight_e;
			err_q    <= err_e;
		end
	end

endmodule

>>> hw/rtl/hpp_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the classifier and the output stage.
module hpp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  hpp_pkg::out_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output hpp_pkg::out_t pop_data
);
	import hpp_pkg::*;

	out_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

>>> hw/rtl/hpp_back.sv
`timescale 1ns / 1ps
// Output stage: registers each result and holds it until it is taken.
module hpp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  hpp_pkg::out_t pop_data,
	output logic          out_valid,
	input  logic          out_ready,
	output hpp_pkg::out_t out_data
);
	import hpp_pkg::*;

	logic valid_q;
	out_t data_q;

	assign pop_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			data_q <= pop_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

endmodule

>>> hw/rtl/headers_payload_parser_core.sv
`timescale 1ns / 1ps
// HEADERS frame payload parser: one result per payload byte.
// Each result passes through the queue and then the output register before it is valid.
// Throughput: one byte per cycle while the queue has room; the classifier updates frame state on each accepted byte.
// A two-entry queue lets the classifier keep going while a result waits.
// Reset (arst_n low) clears frame state, queue and output valid; no frame is open.
module headers_payload_parser_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_ready,
	input  hpp_pkg::in_t  byte_data,
	output logic          result_valid,
	input  logic          result_ready,
	output hpp_pkg::out_t result_data
);
	import hpp_pkg::*;

	logic push_valid, push_ready, pop_valid, pop_ready;
	out_t push_data, pop_data;

	hpp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (byte_valid),
		.in_ready   (byte_ready),
		.in_data    (byte_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	hpp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	hpp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.out_data  (result_data)
	);

endmodule
